>>> sv/cbs_pkg.sv
// cbs_pkg: shared types and constants of the column bounds to spans block
// no dependencies; imported by cbs_step, cbs_row_mem and column_bounds_to_spans_core
`default_nettype none

package cbs_pkg;

   // field widths of the streams
   localparam int unsigned X_W     = 11;  // column index
   localparam int unsigned TOP_W   = 7;   // top row, also the width of every row cursor
   localparam int unsigned BOT_W   = 6;   // bottom row
   localparam int unsigned ROW_W   = 6;   // row of a span
   localparam int unsigned RIGHT_W = 10;  // last column of a span
   localparam int unsigned REQ_W   = 24;  // packed request data
   localparam int unsigned RSP_W   = 32;  // packed response data, padded to bytes
   localparam int unsigned PAD_W   = RSP_W - ROW_W - X_W - RIGHT_W;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   // row cursors of one column
   typedef struct packed {
      logic [TOP_W-1:0] t1;  // previous top, advanced by top closes
      logic [TOP_W-1:0] b1;  // previous bottom, retreated by bottom closes
      logic [TOP_W-1:0] t2;  // new top
      logic [TOP_W-1:0] b2;  // new bottom
      logic [TOP_W-1:0] ot;  // open cursor from the top
      logic [TOP_W-1:0] ob;  // open cursor from the bottom
   } cursor_type;

   // one step decided by the cursor unit
   typedef struct packed {
      logic             emit;  // close a row and send a span
      logic             write; // record the start column of a row
      logic             last;  // no further span for this column
      logic [TOP_W-1:0] row;   // row being closed or opened
      cursor_type       nxt;   // cursors after this step
   } step_type;

endpackage : cbs_pkg

`default_nettype wire

>>> sv/cbs_step.sv
// cbs_step: shared cursor unit, one close or open action per cycle
// depends on cbs_pkg
`default_nettype none

module cbs_step (
   input  wire cbs_pkg::cursor_type cur,
   output cbs_pkg::step_type        step
);
   import cbs_pkg::*;

   logic             top_close;
   logic             bot_close;
   logic             top_open;
   logic             bot_open;
   logic [TOP_W-1:0] t1_inc;
   logic [TOP_W-1:0] b1_dec;
   logic             more_after_top;
   logic             more_after_bot;

   // conditions of the four phases, in priority order
   assign top_close = (cur.t2 > cur.t1) && (cur.t1 <= cur.b1);
   assign bot_close = (cur.b2 < cur.b1) && (cur.t1 <= cur.b1);
   assign top_open  = (cur.ot < cur.t1) && (cur.ot <= cur.ob);
   assign bot_open  = (cur.ob > cur.b1) && (cur.ot <= cur.ob);

   assign t1_inc = cur.t1 + TOP_W'(1);
   assign b1_dec = cur.b1 - TOP_W'(1);

   // is there another span once this one is gone
   assign more_after_top = (t1_inc <= cur.b1) && ((cur.t2 > t1_inc) || (cur.b2 < cur.b1));
   assign more_after_bot = (cur.t1 <= b1_dec) && (cur.b2 < b1_dec);

   // pick the action and advance its cursor
   always_comb begin
      step       = '0;
      step.nxt   = cur;
      if (top_close) begin
         step.emit   = 1'b1;
         step.row    = cur.t1;
         step.last   = !more_after_top;
         step.nxt.t1 = t1_inc;
      end else if (bot_close) begin
         step.emit   = 1'b1;
         step.row    = cur.b1;
         step.last   = !more_after_bot;
         step.nxt.b1 = b1_dec;
      end else if (top_open) begin
         step.write  = 1'b1;
         step.row    = cur.ot;
         step.nxt.ot = cur.ot + TOP_W'(1);
      end else if (bot_open) begin
         step.write  = 1'b1;
         step.row    = cur.ob;
         step.nxt.ob = cur.ob - TOP_W'(1);
      end
   end

endmodule : cbs_step

`default_nettype wire

>>> sv/cbs_row_mem.sv
// cbs_row_mem: start column of each open row, one write and one registered read
// depends on cbs_pkg
`default_nettype none

module cbs_row_mem #(
   parameter int unsigned ROWS = 64
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire  [$clog2(ROWS)-1:0]       wr_addr,
   input  wire  [cbs_pkg::X_W-1:0]       wr_data,
   input  wire                           rd_en,
   input  wire  [$clog2(ROWS)-1:0]       rd_addr,
   output logic [cbs_pkg::X_W-1:0]       rd_data
);
   import cbs_pkg::*;

   logic [X_W-1:0] mem [ROWS];
   logic [X_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : cbs_row_mem

`default_nettype wire

>>> sv/column_bounds_to_spans_core.sv
// column_bounds_to_spans_core: one column item in, one span item per closed row out
// first span item: the column item is registered into the cursors, and each span is registered in the response register
// rows: one close or open per cycle through the shared cursor unit and the start memory,
// held while a span waits on rsp_tready; a new column item is taken only once idle again
// reset: synchronous, previous range set to empty; start memory not cleared
// depends on cbs_pkg, cbs_step, cbs_row_mem
`default_nettype none

module column_bounds_to_spans_core #(
   parameter int unsigned ROWS = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   // request: col_x [10:0], col_top [17:11], col_bot [23:18]
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [cbs_pkg::REQ_W-1:0]    req_tdata,
   // request: first_col [0]
   input  wire                          req_tuser,
   // response: span_row [5:0], span_left [16:6], span_right [26:17], zeros [31:27]
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [cbs_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                         rsp_tlast
);
   import cbs_pkg::*;

   localparam int unsigned AW = $clog2(ROWS);
   localparam logic [TOP_W-1:0] ROWS_V = TOP_W'(ROWS);

   state_type          state_ff, state_in;
   cursor_type         cur_ff, cur_in;
   logic [TOP_W-1:0]   prev_top_ff, prev_top_in;
   logic [BOT_W-1:0]   prev_bot_ff, prev_bot_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic [RIGHT_W-1:0] right_ff, right_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [RIGHT_W-1:0] rsp_right_ff, rsp_right_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [X_W-1:0]     col_x;
   logic [TOP_W-1:0]   col_top;
   logic [BOT_W-1:0]   col_bot;
   logic [TOP_W-1:0]   new_top;
   logic [TOP_W-1:0]   new_bot;
   logic               accept;
   logic               busy;
   logic               stall;
   logic [X_W-1:0]     span_left;
   step_type           step;

   // unpack the request item
   assign col_x   = req_tdata[X_W-1:0];
   assign col_top = req_tdata[X_W+TOP_W-1:X_W];
   assign col_bot = req_tdata[X_W+TOP_W+BOT_W-1:X_W+TOP_W];

   // empty column and bottom saturation
   always_comb begin
      new_top = col_top;
      new_bot = TOP_W'(col_bot);
      if (col_top >= ROWS_V) begin
         new_top = ROWS_V;
         new_bot = '0;
      end else if (TOP_W'(col_bot) >= ROWS_V) begin
         new_bot = ROWS_V - TOP_W'(1);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign busy       = (state_ff == ST_BUSY);

   cbs_step u_step (
      .cur  (cur_ff),
      .step (step)
   );

   // a span waits while the response register is still full
   assign stall = step.emit && rsp_valid_ff && !rsp_tready;

   cbs_row_mem #(
      .ROWS (ROWS)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (busy && step.write),
      .wr_addr (step.row[AW-1:0]),
      .wr_data (x_ff),
      .rd_en   (busy && step.emit && !stall),
      .rd_addr (step.row[AW-1:0]),
      .rd_data (span_left)
   );

   // sequencer and cursor update
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_top_in  = prev_top_ff;
      prev_bot_in  = prev_bot_ff;
      x_in         = x_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in.t1   = req_tuser ? ROWS_V : prev_top_ff;
               cur_in.b1   = req_tuser ? '0 : TOP_W'(prev_bot_ff);
               cur_in.t2   = new_top;
               cur_in.b2   = new_bot;
               cur_in.ot   = new_top;
               cur_in.ob   = new_bot;
               prev_top_in = new_top;
               prev_bot_in = new_bot[BOT_W-1:0];
               x_in        = col_x;
               right_in    = col_x[RIGHT_W-1:0] - RIGHT_W'(1);
               state_in    = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (!stall) begin
               cur_in = step.nxt;
               if (step.emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = step.row[ROW_W-1:0];
                  rsp_right_in = right_ff;
                  rsp_last_in  = step.last;
               end
               if (!step.emit && !step.write) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_top_ff  <= ROWS_V;
         prev_bot_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_top_ff  <= prev_top_in;
         prev_bot_ff  <= prev_bot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      x_ff         <= x_in;
      right_ff     <= right_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // pack the response item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_right_ff, span_left, rsp_row_ff};

endmodule : column_bounds_to_spans_core

`default_nettype wire
